// ===== design/ray_sphere_intersect_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray/sphere intersection block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

`ifndef SYNTH
// Check a property on a given clock and active-low reset
`define RSI_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the block clock and reset
`define RSI_ASSERT(lbl, prop, msg) \
  `RSI_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define RSI_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define RSI_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== design/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Transaction payload types and register indexes of the ray/sphere block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgCenterX   = 2'd0,
    CfgCenterY   = 2'd1,
    CfgCenterZ   = 2'd2,
    CfgRadiusSq  = 2'd3
  } rsi_cfg_e;

  localparam logic [31:0] RadiusSqReset = 32'h0001_0000;

  // One ray, all Q16.16
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] near_limit;
    logic signed [31:0] far_limit;
  } rsi_in_t;

  // One test result: Q16.16 time, Q2.14 normal
  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_time;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } rsi_out_t;

endpackage

`default_nettype wire

// ===== design/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Fixed-point ray/sphere hit test with near hit time and unit surface normal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one ray per
//   transaction: origin, direction and an open time interval. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one result per
//   ray, in order: hit flag, near hit time and unit normal (zeros on a miss).
//   The sphere centre and squared radius are set through the write port
//   (cfg_we_i, cfg_index_i, cfg_data_i) while no ray is in flight.
// Pipeline:
//   One ray is taken every cycle while the output is not stalled. The depth
//   comes from two bit-per-stage square roots (50 and 49 stages) and two
//   bit-per-stage dividers (31 stages for the roots, 15 for the normal), plus
//   the multiply and sum stages around them.
// Reset and stall:
//   Reset empties the pipeline and loads centre zero, squared radius 1.0.
//   While a result waits at the output and out_stall_i is high, the whole
//   pipeline holds and in_stall_o is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  rsi_pkg::rsi_in_t       in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rsi_pkg::rsi_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  rsi_pkg::rsi_cfg_e      cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  localparam int DiscW = 100;  // discriminant width
  localparam int SqDW  = 50;   // root bits of the discriminant
  localparam int RootW = 31;   // magnitude bits of a root time
  localparam int LsqW  = 98;   // squared normal length width
  localparam int SqLW  = 49;   // root bits of the squared length
  localparam int NrmW  = 15;   // magnitude bits of a normal component

  typedef struct packed {
    logic [2:0][32:0] p;
    logic [2:0][31:0] d;
    logic [31:0]      near_limit;
    logic [31:0]      far_limit;
    logic [47:0]      a;
    logic [49:0]      b;
    logic             miss;
  } ray_ctx_t;

  typedef struct packed {
    logic [2:0][32:0] p;
    logic [2:0][31:0] d;
    logic             hit;
    logic [31:0]      t1;
  } hit_ctx_t;

  typedef struct packed {
    logic             hit;
    logic [31:0]      t1;
    logic [2:0]       neg;
    logic [2:0][47:0] mag;
  } nrm_ctx_t;

  // Global advance: hold everything while the output waits
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Configuration registers
  logic [31:0] center_x_q, center_y_q, center_z_q, radius_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      center_z_q  <= '0;
      radius_sq_q <= rsi_pkg::RadiusSqReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rsi_pkg::CfgCenterX:  center_x_q  <= cfg_data_i;
        rsi_pkg::CfgCenterY:  center_y_q  <= cfg_data_i;
        rsi_pkg::CfgCenterZ:  center_z_q  <= cfg_data_i;
        rsi_pkg::CfgRadiusSq: radius_sq_q <= cfg_data_i;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front: offset origin, products, sums, discriminant partial products
  // --------------------------------------------------------------------------
  logic                v1_q, v2_q, v3_q, v4_q, v5_q;
  ray_ctx_t            ctx1_d, ctx1_q, ctx2_q, ctx3_d, ctx3_q, ctx4_q, ctx5_q;
  logic [2:0][47:0]    a2_d, a2_q, c2_d, c2_q;
  logic [2:0][48:0]    b2_d, b2_q;
  logic [50:0]         cq3_d, cq3_q;
  logic [49:0]         bhh4_d, bhl4_d, bll4_d, ahch4_d, ahcl4_d, alch4_d, alcl4_d;
  logic [49:0]         bhh4_q, bhl4_q, bll4_q, ahch4_q, ahcl4_q, alch4_q, alcl4_q;
  logic                cneg4_q;
  logic [DiscW-1:0]    bb5_d, ac5_d, bb5_q, ac5_q;
  logic                cneg5_q;

  // Stage 1: relative origin
  always_comb begin
    ctx1_d            = '0;
    ctx1_d.p[0]       = {in_data_i.origin_x[31], in_data_i.origin_x}
                        - {center_x_q[31], center_x_q};
    ctx1_d.p[1]       = {in_data_i.origin_y[31], in_data_i.origin_y}
                        - {center_y_q[31], center_y_q};
    ctx1_d.p[2]       = {in_data_i.origin_z[31], in_data_i.origin_z}
                        - {center_z_q[31], center_z_q};
    ctx1_d.d[0]       = in_data_i.dir_x;
    ctx1_d.d[1]       = in_data_i.dir_y;
    ctx1_d.d[2]       = in_data_i.dir_z;
    ctx1_d.near_limit = in_data_i.near_limit;
    ctx1_d.far_limit  = in_data_i.far_limit;
  end

  // Stage 2: per-axis products, floored back to Q.16
  always_comb begin
    logic signed [63:0] dd;
    logic signed [64:0] pd;
    logic signed [65:0] pp;
    for (int i = 0; i < 3; i++) begin
      dd      = $signed(ctx1_q.d[i]) * $signed(ctx1_q.d[i]);
      pd      = $signed(ctx1_q.p[i]) * $signed(ctx1_q.d[i]);
      pp      = $signed(ctx1_q.p[i]) * $signed(ctx1_q.p[i]);
      a2_d[i] = dd[63:16];
      b2_d[i] = pd[64:16];
      c2_d[i] = pp[63:16];
    end
  end

  // Stage 3: quadratic coefficients
  always_comb begin
    logic [49:0] csum;
    ctx3_d      = ctx2_q;
    ctx3_d.a    = a2_q[0] + a2_q[1] + a2_q[2];
    ctx3_d.b    = {b2_q[0][48], b2_q[0]} + {b2_q[1][48], b2_q[1]}
                  + {b2_q[2][48], b2_q[2]};
    ctx3_d.miss = (ctx3_d.a == '0);
    csum        = {2'b0, c2_q[0]} + {2'b0, c2_q[1]} + {2'b0, c2_q[2]};
    cq3_d       = {1'b0, csum} - {19'b0, radius_sq_q};
  end

  // Stage 4: 25-bit partial products of B*B and A*|Cq|
  always_comb begin
    logic [49:0] bm_w, cm_w;
    logic [48:0] bm;
    logic [49:0] cm;
    bm_w    = ctx3_q.b[49] ? (50'd0 - ctx3_q.b) : ctx3_q.b;
    bm      = bm_w[48:0];
    cm_w    = cq3_q[50] ? cq3_q[49:0] ^ {50{1'b1}} : cq3_q[49:0];
    cm      = cq3_q[50] ? cm_w + 50'd1 : cm_w;
    bhh4_d  = 50'(bm[48:25]) * 50'(bm[48:25]);
    bhl4_d  = 50'(bm[48:25]) * 50'(bm[24:0]);
    bll4_d  = 50'(bm[24:0])  * 50'(bm[24:0]);
    ahch4_d = 50'(ctx3_q.a[47:25]) * 50'(cm[49:25]);
    ahcl4_d = 50'(ctx3_q.a[47:25]) * 50'(cm[24:0]);
    alch4_d = 50'(ctx3_q.a[24:0])  * 50'(cm[49:25]);
    alcl4_d = 50'(ctx3_q.a[24:0])  * 50'(cm[24:0]);
  end

  // Stage 5: assemble B*B and A*|Cq|
  always_comb begin
    bb5_d = (DiscW'(bhh4_q) << 50) + (DiscW'(bhl4_q) << 26) + DiscW'(bll4_q);
    ac5_d = (DiscW'(ahch4_q) << 50) + (DiscW'(ahcl4_q) << 25)
            + (DiscW'(alch4_q) << 25) + DiscW'(alcl4_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx1_q  <= ctx1_d;
      ctx2_q  <= ctx1_q;
      a2_q    <= a2_d;
      b2_q    <= b2_d;
      c2_q    <= c2_d;
      ctx3_q  <= ctx3_d;
      cq3_q   <= cq3_d;
      ctx4_q  <= ctx3_q;
      cneg4_q <= cq3_q[50];
      bhh4_q  <= bhh4_d;
      bhl4_q  <= bhl4_d;
      bll4_q  <= bll4_d;
      ahch4_q <= ahch4_d;
      ahcl4_q <= ahcl4_d;
      alch4_q <= alch4_d;
      alcl4_q <= alcl4_d;
      ctx5_q  <= ctx4_q;
      bb5_q   <= bb5_d;
      ac5_q   <= ac5_d;
      cneg5_q <= cneg4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Discriminant and its square root, one result bit per stage
  // --------------------------------------------------------------------------
  logic [DiscW-1:0] dsq_rem_q  [SqDW+1];
  logic [SqDW-1:0]  dsq_root_q [SqDW+1];
  ray_ctx_t         dsq_ctx_q  [SqDW+1];
  logic             dsq_v_q    [SqDW+1];
  ray_ctx_t         dsq0_ctx_d;
  logic [DiscW-1:0] dsq0_rem_d;

  // Stage 6: discriminant, miss when negative
  always_comb begin
    dsq0_ctx_d = ctx5_q;
    dsq0_rem_d = '0;
    if (cneg5_q) begin
      dsq0_rem_d = bb5_q + ac5_q;
    end else if (ac5_q > bb5_q) begin
      dsq0_ctx_d.miss = 1'b1;
    end else begin
      dsq0_rem_d = bb5_q - ac5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsq_rem_q[0]  <= dsq0_rem_d;
      dsq_root_q[0] <= '0;
      dsq_ctx_q[0]  <= dsq0_ctx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsq_v_q[0] <= 1'b0;
    end else if (adv) begin
      dsq_v_q[0] <= v5_q;
    end
  end

  for (genvar k = 0; k < SqDW; k++) begin : g_dsq
    localparam int Bit = SqDW - 1 - k;
    logic [DiscW-1:0] trial;
    logic [DiscW:0]   diff;
    logic             ge;

    // Try the next root bit against the remainder
    assign trial = (DiscW'(dsq_root_q[k]) << (Bit + 1)) | (DiscW'(1) << (2 * Bit));
    assign diff  = {1'b0, dsq_rem_q[k]} - {1'b0, trial};
    assign ge    = !diff[DiscW];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dsq_rem_q[k+1]  <= ge ? diff[DiscW-1:0] : dsq_rem_q[k];
        dsq_root_q[k+1] <= ge ? (dsq_root_q[k] | (SqDW'(1) << Bit)) : dsq_root_q[k];
        dsq_ctx_q[k+1]  <= dsq_ctx_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dsq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dsq_v_q[k+1] <= dsq_v_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Root times: (-B -/+ s) * 2^16 / A, saturated at 2^31 magnitude
  // --------------------------------------------------------------------------
  logic [1:0][66:0]      dv_rem_q [RootW+1];
  logic [1:0][RootW-1:0] dv_quo_q [RootW+1];
  logic [1:0]            dv_neg_q [RootW+1];
  logic [1:0]            dv_ovf_q [RootW+1];
  ray_ctx_t              dv_ctx_q [RootW+1];
  logic                  dv_v_q   [RootW+1];
  logic [1:0][66:0]      dv0_rem_d;
  logic [1:0]            dv0_neg_d, dv0_ovf_d;

  // Numerators of the near and far roots
  always_comb begin
    logic [51:0]      nb;
    logic [1:0][51:0] n;
    logic [51:0]      nm;
    nb   = 52'd0 - {{2{dsq_ctx_q[SqDW].b[49]}}, dsq_ctx_q[SqDW].b};
    n[0] = nb - {2'b0, dsq_root_q[SqDW]};
    n[1] = nb + {2'b0, dsq_root_q[SqDW]};
    for (int j = 0; j < 2; j++) begin
      nm           = n[j][51] ? (52'd0 - n[j]) : n[j];
      dv0_neg_d[j] = n[j][51];
      dv0_ovf_d[j] = {12'b0, nm[50:0]} >= ({15'b0, dsq_ctx_q[SqDW].a} << 15);
      dv0_rem_d[j] = {nm[50:0], 16'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0] <= dv0_rem_d;
      dv_quo_q[0] <= '0;
      dv_neg_q[0] <= dv0_neg_d;
      dv_ovf_q[0] <= dv0_ovf_d;
      dv_ctx_q[0] <= dsq_ctx_q[SqDW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= dsq_v_q[SqDW];
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_dv
    localparam int Bit = RootW - 1 - k;
    logic [1:0][79:0] diff;
    logic [1:0]       ge;

    // Subtract the shifted divisor where it fits
    always_comb begin
      for (int j = 0; j < 2; j++) begin
        diff[j] = 80'(dv_rem_q[k][j]) - (80'(dv_ctx_q[k].a) << Bit);
        ge[j]   = !diff[j][79];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int j = 0; j < 2; j++) begin
          dv_rem_q[k+1][j] <= ge[j] ? diff[j][66:0] : dv_rem_q[k][j];
          dv_quo_q[k+1][j] <= ge[j] ? (dv_quo_q[k][j] | (RootW'(1) << Bit))
                                    : dv_quo_q[k][j];
        end
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_ovf_q[k+1] <= dv_ovf_q[k];
        dv_ctx_q[k+1] <= dv_ctx_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hit decision, hit point and squared normal length
  // --------------------------------------------------------------------------
  logic             vc_q, vn1_q, vn2_q, vn3_q, vn4_q;
  hit_ctx_t         hc_d, hc_q, hn1_q;
  logic [2:0][47:0] td_d, td_q;
  nrm_ctx_t         nc2_d, nc2_q, nc3_q, nc4_q;
  logic [2:0][47:0] hh3_d, hl3_d, ll3_d, hh3_q, hl3_q, ll3_q;
  logic [2:0][95:0] sq4_d, sq4_q;

  // Compare both roots with the open interval
  always_comb begin
    logic [1:0][31:0] tm;
    logic [1:0][32:0] t;
    for (int j = 0; j < 2; j++) begin
      tm[j] = dv_ovf_q[RootW][j] ? 32'h8000_0000 : {1'b0, dv_quo_q[RootW][j]};
      t[j]  = dv_neg_q[RootW][j] ? (33'd0 - {1'b0, tm[j]}) : {1'b0, tm[j]};
    end
    hc_d.p   = dv_ctx_q[RootW].p;
    hc_d.d   = dv_ctx_q[RootW].d;
    hc_d.t1  = t[0][31:0];
    hc_d.hit = !dv_ctx_q[RootW].miss
               && ($signed(t[0]) > $signed({dv_ctx_q[RootW].near_limit[31],
                                            dv_ctx_q[RootW].near_limit}))
               && ($signed(t[1]) < $signed({dv_ctx_q[RootW].far_limit[31],
                                            dv_ctx_q[RootW].far_limit}));
  end

  // Time times direction, floored to Q.16
  always_comb begin
    logic signed [63:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod    = $signed(hc_q.t1) * $signed(hc_q.d[i]);
      td_d[i] = prod[63:16];
    end
  end

  // Hit point relative to the centre, as sign and magnitude
  always_comb begin
    logic [48:0] q;
    logic [48:0] qm;
    nc2_d.hit = hn1_q.hit;
    nc2_d.t1  = hn1_q.t1;
    for (int i = 0; i < 3; i++) begin
      q             = {{16{hn1_q.p[i][32]}}, hn1_q.p[i]} + {td_q[i][47], td_q[i]};
      qm            = q[48] ? (49'd0 - q) : q;
      nc2_d.neg[i]  = q[48];
      nc2_d.mag[i]  = qm[47:0];
    end
  end

  // 24-bit partial products of each squared component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh3_d[i] = 48'(nc2_q.mag[i][47:24]) * 48'(nc2_q.mag[i][47:24]);
      hl3_d[i] = 48'(nc2_q.mag[i][47:24]) * 48'(nc2_q.mag[i][23:0]);
      ll3_d[i] = 48'(nc2_q.mag[i][23:0])  * 48'(nc2_q.mag[i][23:0]);
    end
  end

  // Assemble each squared component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = (96'(hh3_q[i]) << 48) + (96'(hl3_q[i]) << 25) + 96'(ll3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hc_q  <= hc_d;
      hn1_q <= hc_q;
      td_q  <= td_d;
      nc2_q <= nc2_d;
      nc3_q <= nc2_q;
      hh3_q <= hh3_d;
      hl3_q <= hl3_d;
      ll3_q <= ll3_d;
      nc4_q <= nc3_q;
      sq4_q <= sq4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= 1'b0;
      vn1_q <= 1'b0;
      vn2_q <= 1'b0;
      vn3_q <= 1'b0;
      vn4_q <= 1'b0;
    end else if (adv) begin
      vc_q  <= dv_v_q[RootW];
      vn1_q <= vc_q;
      vn2_q <= vn1_q;
      vn3_q <= vn2_q;
      vn4_q <= vn3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Normal length: square root, one result bit per stage
  // --------------------------------------------------------------------------
  logic [LsqW-1:0] lsq_rem_q  [SqLW+1];
  logic [SqLW-1:0] lsq_root_q [SqLW+1];
  nrm_ctx_t        lsq_ctx_q  [SqLW+1];
  logic            lsq_v_q    [SqLW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lsq_rem_q[0]  <= LsqW'(sq4_q[0]) + LsqW'(sq4_q[1]) + LsqW'(sq4_q[2]);
      lsq_root_q[0] <= '0;
      lsq_ctx_q[0]  <= nc4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsq_v_q[0] <= 1'b0;
    end else if (adv) begin
      lsq_v_q[0] <= vn4_q;
    end
  end

  for (genvar k = 0; k < SqLW; k++) begin : g_lsq
    localparam int Bit = SqLW - 1 - k;
    logic [LsqW-1:0] trial;
    logic [LsqW:0]   diff;
    logic            ge;

    // Try the next root bit against the remainder
    assign trial = (LsqW'(lsq_root_q[k]) << (Bit + 1)) | (LsqW'(1) << (2 * Bit));
    assign diff  = {1'b0, lsq_rem_q[k]} - {1'b0, trial};
    assign ge    = !diff[LsqW];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        lsq_rem_q[k+1]  <= ge ? diff[LsqW-1:0] : lsq_rem_q[k];
        lsq_root_q[k+1] <= ge ? (lsq_root_q[k] | (SqLW'(1) << Bit)) : lsq_root_q[k];
        lsq_ctx_q[k+1]  <= lsq_ctx_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lsq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        lsq_v_q[k+1] <= lsq_v_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normal components: |Q| * 2^14 / L, three lanes
  // --------------------------------------------------------------------------
  logic [2:0][61:0]     nd_rem_q [NrmW+1];
  logic [2:0][NrmW-1:0] nd_quo_q [NrmW+1];
  logic [SqLW-1:0]      nd_len_q [NrmW+1];
  nrm_ctx_t             nd_ctx_q [NrmW+1];
  logic                 nd_v_q   [NrmW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nd_rem_q[0][i] <= {lsq_ctx_q[SqLW].mag[i], 14'b0};
      end
      nd_quo_q[0] <= '0;
      nd_len_q[0] <= lsq_root_q[SqLW];
      nd_ctx_q[0] <= lsq_ctx_q[SqLW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_v_q[0] <= 1'b0;
    end else if (adv) begin
      nd_v_q[0] <= lsq_v_q[SqLW];
    end
  end

  for (genvar k = 0; k < NrmW; k++) begin : g_nd
    localparam int Bit = NrmW - 1 - k;
    logic [2:0][63:0] diff;
    logic [2:0]       ge;

    // Subtract the shifted length where it fits
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        diff[i] = 64'(nd_rem_q[k][i]) - (64'(nd_len_q[k]) << Bit);
        ge[i]   = !diff[i][63];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          nd_rem_q[k+1][i] <= ge[i] ? diff[i][61:0] : nd_rem_q[k][i];
          nd_quo_q[k+1][i] <= ge[i] ? (nd_quo_q[k][i] | (NrmW'(1) << Bit))
                                    : nd_quo_q[k][i];
        end
        nd_len_q[k+1] <= nd_len_q[k];
        nd_ctx_q[k+1] <= nd_ctx_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nd_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        nd_v_q[k+1] <= nd_v_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  rsi_pkg::rsi_out_t out_d, out_q;
  logic              out_valid_q;

  // Sign the normal, zero all fields on a miss
  always_comb begin
    logic [2:0][15:0] nrm;
    for (int i = 0; i < 3; i++) begin
      if (nd_len_q[NrmW] == '0) begin
        nrm[i] = '0;
      end else if (nd_ctx_q[NrmW].neg[i]) begin
        nrm[i] = 16'd0 - {1'b0, nd_quo_q[NrmW][i]};
      end else begin
        nrm[i] = {1'b0, nd_quo_q[NrmW][i]};
      end
    end
    out_d = '0;
    if (nd_ctx_q[NrmW].hit) begin
      out_d.hit      = 1'b1;
      out_d.hit_time = nd_ctx_q[NrmW].t1;
      out_d.normal_x = nrm[0];
      out_d.normal_y = nrm[1];
      out_d.normal_z = nrm[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= nd_v_q[NrmW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RSI_ASSERT(a_miss_zero, out_valid_o && !out_data_o.hit |-> out_data_o.hit_time == '0 && out_data_o.normal_x == '0 && out_data_o.normal_y == '0 && out_data_o.normal_z == '0, "miss result carries nonzero fields")
  `RSI_ASSERT(a_normal_range, out_valid_o && out_data_o.hit |-> $signed(out_data_o.normal_x) <= 16384 && $signed(out_data_o.normal_x) >= -16384 && $signed(out_data_o.normal_y) <= 16384 && $signed(out_data_o.normal_y) >= -16384 && $signed(out_data_o.normal_z) <= 16384 && $signed(out_data_o.normal_z) >= -16384, "normal component out of unit range")
  `RSI_ASSERT(a_hold_on_stall, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o) && $stable(nd_v_q[NrmW]), "pipeline moved while output stalled")
  `RSI_ASSERT(a_hit_not_miss, vc_q && hc_q.hit |-> $past(!dv_ctx_q[RootW].miss || !adv), "hit flagged on a missed ray")

endmodule

`default_nettype wire
